// ===== rtl/core/stg_pkg.sv =====
// shared types, constants and the quarter-wave sine table function of the sine tone generator
package stg_pkg;

   localparam int CSR_W    = 32;
   localparam int AMP_W    = 15;
   localparam int COEF_W   = 15;
   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = 30;

   // rounding bias and full scale of the q1.15 table
   localparam logic [PROD_W-1:0] ROUND_BIAS = 30'd16383;
   localparam logic [COEF_W:0]   FULL_SCALE = 16'd32767;

   // reset values of the configuration registers
   localparam logic [CSR_W-1:0] RESET_PHASE_STEP   = 32'd89478485;
   localparam logic [CSR_W-1:0] RESET_PHASE_OFFSET = 32'd0;
   localparam logic [AMP_W-1:0] RESET_AMPLITUDE    = 15'd16384;
   localparam logic [CSR_W-1:0] RESET_SAMPLE_COUNT = 32'd48000;

   typedef enum logic [1:0] {
      REG_PHASE_STEP   = 2'd0,
      REG_PHASE_OFFSET = 2'd1,
      REG_AMPLITUDE    = 2'd2,
      REG_SAMPLE_COUNT = 2'd3
   } csr_index_type;

   // sideband that travels with a sample through the pipeline
   typedef struct packed {
      logic valid;
      logic neg;
      logic last;
   } stg_side_type;

   // q1.15 sine of pi/2 * j / 2^table_bits, integer taylor series through x^17
   function automatic logic [COEF_W-1:0] quarter_sine(input int unsigned j,
                                                      input int unsigned table_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          s;
      longint          v;
      x    = (64'd1686629713 * longint'(j)) >> table_bits;
      x2   = (x * x) >> 30;
      term = x;
      s    = longint'(x);
      term = ((term * x2) >> 30) / 6;   s = s - longint'(term);
      term = ((term * x2) >> 30) / 20;  s = s + longint'(term);
      term = ((term * x2) >> 30) / 42;  s = s - longint'(term);
      term = ((term * x2) >> 30) / 72;  s = s + longint'(term);
      term = ((term * x2) >> 30) / 110; s = s - longint'(term);
      term = ((term * x2) >> 30) / 156; s = s + longint'(term);
      term = ((term * x2) >> 30) / 210; s = s - longint'(term);
      term = ((term * x2) >> 30) / 272; s = s + longint'(term);
      if (s < 0) begin
         s = 0;
      end
      v = longint'((longint'(s) * 32767 + (64'd1 << 29)) >> 30);
      if (v > 32767) begin
         v = 32767;
      end
      return v[COEF_W-1:0];
   endfunction

endpackage

// ===== rtl/core/stg_sine_rom.sv =====
// quarter-wave sine table with registered read
module stg_sine_rom #(
   parameter int TABLE_BITS = 8
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [TABLE_BITS:0]           addr,
   output logic [stg_pkg::COEF_W-1:0]    data
);
   import stg_pkg::*;

   localparam int DEPTH = (1 << TABLE_BITS) + 1;

   logic [COEF_W-1:0] rom_entry [DEPTH];
   logic [COEF_W-1:0] data_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : gen_rom
      assign rom_entry[g] = quarter_sine(g, TABLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= rom_entry[addr];
      end
   end

   assign data = data_ff;

endmodule

// ===== rtl/core/stg_scale.sv =====
// amplitude scaling, rounding divide by full scale and sign, two register stages
module stg_scale (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  stg_pkg::stg_side_type           in_side,
   input  logic [stg_pkg::COEF_W-1:0]      in_coef,
   input  logic [stg_pkg::AMP_W-1:0]       amplitude,
   output logic                            out_valid,
   output logic signed [stg_pkg::SAMPLE_W-1:0] out_sample,
   output logic                            out_last
);
   import stg_pkg::*;

   stg_side_type               mid_side_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic [PROD_W-1:0]          prod_in;
   logic [COEF_W-1:0]          quot_lo;
   logic [COEF_W:0]            rem;
   logic [COEF_W:0]            quot;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic                       valid_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       last_ff;

   assign prod_in = PROD_W'(amplitude) * PROD_W'(in_coef) + ROUND_BIAS;

   // x / 32767 is x >> 15 or one more; remainder of the low guess is x[14:0] + guess
   assign quot_lo   = prod_ff[PROD_W-1 -: COEF_W];
   assign rem       = {1'b0, prod_ff[COEF_W-1:0]} + {1'b0, quot_lo};
   assign quot      = {1'b0, quot_lo} + {{COEF_W{1'b0}}, (rem >= FULL_SCALE)};
   assign sample_in = mid_side_ff.neg ? -$signed(quot) : $signed(quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_side_ff <= '0;
         valid_ff    <= 1'b0;
      end else if (enable) begin
         mid_side_ff <= in_side;
         valid_ff    <= mid_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff   <= prod_in;
         sample_ff <= sample_in;
         last_ff   <= mid_side_ff.last;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;
   assign out_last   = last_ff;

endmodule

// ===== rtl/core/sine_tone_generator.sv =====
// sine tone generator top level: phase accumulator, table lookup pipeline and control registers
//
//   channel | ports                                   | direction | transfer when
//   --------+-----------------------------------------+-----------+----------------------
//   req     | req_valid req_stall req_restart         | in        | req_valid & !req_stall
//   rsp     | rsp_valid rsp_stall rsp_sample rsp_last | out       | rsp_valid & !rsp_stall
//   csr     | csr_write_enable csr_index csr_data     | in        | csr_write_enable
//
// one request transfer per cycle while req_stall is low; its sample passes each pipeline stage below in order
// pipeline: phase add and table address, table read, amplitude multiply, divide and sign
// a request past the end of the tone keeps phase and count, yields no sample (pipeline bubble)
// a stalled rsp holds the whole pipeline, so req_stall follows rsp_valid & rsp_stall
// synchronous reset clears phase, count, pipeline valids and loads register defaults
module sine_tone_generator #(
   parameter int TABLE_BITS = 8,
   parameter int PHASE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [stg_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                rsp_last,
   input  logic                                csr_write_enable,
   input  stg_pkg::csr_index_type              csr_index,
   input  logic [stg_pkg::CSR_W-1:0]           csr_data
);
   import stg_pkg::*;

   localparam logic [TABLE_BITS:0] QUARTER = {1'b1, {TABLE_BITS{1'b0}}};

   // control registers
   logic [CSR_W-1:0] phase_step_ff;
   logic [CSR_W-1:0] phase_offset_ff;
   logic [AMP_W-1:0] amplitude_ff;
   logic [CSR_W-1:0] sample_count_ff;

   // tone state
   logic [PHASE_BITS-1:0] phase_acc_ff;
   logic [PHASE_BITS-1:0] phase_acc_in;
   logic [CSR_W-1:0]      sample_index_ff;
   logic [CSR_W-1:0]      sample_index_in;

   // first pipeline stage, and the sideband of the second
   stg_side_type          s1_side_ff;
   stg_side_type          s1_side_in;
   logic [TABLE_BITS:0]   s1_addr_ff;
   logic [TABLE_BITS:0]   s1_addr_in;
   stg_side_type          s2_side_ff;

   logic                        advance;
   logic                        req_take;
   logic [PHASE_BITS-1:0]       acc_eff;
   logic [CSR_W-1:0]            index_eff;
   logic                        emit;
   logic [CSR_W+PHASE_BITS-1:0] step_wide;
   logic [CSR_W+PHASE_BITS-1:0] offset_wide;
   logic [PHASE_BITS-1:0]       step_al;
   logic [PHASE_BITS-1:0]       offset_al;
   logic [PHASE_BITS-1:0]       phase;
   logic [1:0]                  quad;
   logic [TABLE_BITS-1:0]       tidx;
   logic [COEF_W-1:0]           coef;

   // whole pipeline moves unless the output register is full and stalled
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign req_take  = req_valid && advance;

   // align 32-bit register values to the accumulator width (top bits kept)
   assign step_wide   = {phase_step_ff, {PHASE_BITS{1'b0}}};
   assign offset_wide = {phase_offset_ff, {PHASE_BITS{1'b0}}};
   assign step_al     = step_wide[CSR_W+PHASE_BITS-1 -: PHASE_BITS];
   assign offset_al   = offset_wide[CSR_W+PHASE_BITS-1 -: PHASE_BITS];

   // restart clears phase and count before this tick
   assign acc_eff   = req_restart ? '0 : phase_acc_ff;
   assign index_eff = req_restart ? '0 : sample_index_ff;
   assign emit      = index_eff < sample_count_ff;

   assign phase = acc_eff + offset_al;
   assign quad  = phase[PHASE_BITS-1 -: 2];
   assign tidx  = phase[PHASE_BITS-3 -: TABLE_BITS];

   // odd quadrants read the table mirrored
   assign s1_addr_in = quad[0] ? (QUARTER - {1'b0, tidx}) : {1'b0, tidx};

   always_comb begin
      s1_side_in.valid = req_take && emit;
      s1_side_in.neg   = quad[1];
      s1_side_in.last  = ({1'b0, index_eff} + 33'd1) == {1'b0, sample_count_ff};
   end

   always_comb begin
      phase_acc_in    = phase_acc_ff;
      sample_index_in = sample_index_ff;
      if (req_take) begin
         phase_acc_in    = emit ? (acc_eff + step_al) : acc_eff;
         sample_index_in = emit ? (index_eff + 32'd1) : index_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= RESET_PHASE_STEP;
         phase_offset_ff <= RESET_PHASE_OFFSET;
         amplitude_ff    <= RESET_AMPLITUDE;
         sample_count_ff <= RESET_SAMPLE_COUNT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_PHASE_STEP:   phase_step_ff   <= csr_data;
            REG_PHASE_OFFSET: phase_offset_ff <= csr_data;
            REG_AMPLITUDE:    amplitude_ff    <= csr_data[AMP_W-1:0];
            REG_SAMPLE_COUNT: sample_count_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff    <= '0;
         sample_index_ff <= '0;
         s1_side_ff      <= '0;
         s2_side_ff      <= '0;
      end else begin
         phase_acc_ff    <= phase_acc_in;
         sample_index_ff <= sample_index_in;
         if (advance) begin
            s1_side_ff <= s1_side_in;
            s2_side_ff <= s1_side_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_addr_ff <= s1_addr_in;
      end
   end

   stg_sine_rom #(
      .TABLE_BITS(TABLE_BITS)
   ) u_rom (
      .clock  (clock),
      .enable (advance),
      .addr   (s1_addr_ff),
      .data   (coef)
   );

   stg_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .in_side    (s2_side_ff),
      .in_coef    (coef),
      .amplitude  (amplitude_ff),
      .out_valid  (rsp_valid),
      .out_sample (rsp_sample),
      .out_last   (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // an emitting tick without restart advances the count by one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_restart && (sample_index_ff < sample_count_ff))
      |=> (sample_index_ff == $past(sample_index_ff) + 32'd1))
      else $error("sample index did not advance on an emitting transfer");

   // tone state changes only on a request transfer
   assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall) |=> ($stable(phase_acc_ff) && $stable(sample_index_ff)))
      else $error("tone state changed without a request transfer");

   // samples stay symmetric, never the most negative code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample != 16'sh8000))
      else $error("sample out of symmetric range");

   // a restart transfer leaves at most one counted sample
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_restart) |=> (sample_index_ff <= 32'd1))
      else $error("restart did not clear the sample index");
`endif

endmodule

// ===== dv/tone_checker.sv =====
// checker for the sine tone generator: mirrors its state and compares every sample transfer
module tone_checker #(
   parameter int TABLE_BITS = 8,
   parameter int PHASE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_restart,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [stg_pkg::SAMPLE_W-1:0] rsp_sample,
   input  logic                                rsp_last,
   input  logic                                csr_write_enable,
   input  stg_pkg::csr_index_type              csr_index,
   input  logic [stg_pkg::CSR_W-1:0]           csr_data,
   output int                                  pending,
   output int                                  fail_count
);
   import stg_pkg::*;

   localparam int ENTRIES = 1 << TABLE_BITS;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } tone_sample_type;

   logic [COEF_W-1:0]     sine_q15 [0:ENTRIES];
   tone_sample_type       expected_samples [$];
   tone_sample_type       head;
   logic [PHASE_BITS-1:0] tone_phase;
   logic [31:0]           tone_index;
   logic [31:0]           step_reg;
   logic [31:0]           offset_reg;
   logic [AMP_W-1:0]      amp_reg;
   logic [31:0]           count_reg;
   int                    mismatch_count = 0;

   assign fail_count = mismatch_count;

   // q1.15 sine of pi/2 * j / ENTRIES by an integer taylor series up to x^17
   function automatic logic [COEF_W-1:0] quarter_wave_entry(input int unsigned j);
      longint unsigned angle;
      longint unsigned angle_sq;
      longint unsigned term;
      longint          series;
      angle    = (64'd1686629713 * j) >> TABLE_BITS;
      angle_sq = (angle * angle) >> 30;
      term     = angle;
      series   = $signed(angle);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * angle_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            series = series - $signed(term);
         end else begin
            series = series + $signed(term);
         end
      end
      if (series < 0) begin
         series = 0;
      end
      series = (series * 32767 + 536870912) >>> 30;
      if (series > 32767) begin
         series = 32767;
      end
      return series[COEF_W-1:0];
   endfunction

   // a 32-bit register brought to the accumulator width
   function automatic logic [PHASE_BITS-1:0] to_phase(input logic [31:0] value);
      longint unsigned wide;
      wide = value;
      if (PHASE_BITS >= 32) begin
         wide = wide << (PHASE_BITS - 32);
      end else begin
         wide = wide >> (32 - PHASE_BITS);
      end
      return wide[PHASE_BITS-1:0];
   endfunction

   // one tick of the oscillator; queues the sample it emits, if any
   function void predict_tick(input logic restart);
      logic [PHASE_BITS-1:0] phase;
      logic [1:0]            quadrant;
      logic [TABLE_BITS-1:0] slot;
      int                    coef;
      int                    magnitude;
      tone_sample_type       item;
      if (restart) begin
         tone_phase = '0;
         tone_index = '0;
      end
      if (tone_index < count_reg) begin
         phase    = tone_phase + to_phase(offset_reg);
         quadrant = phase[PHASE_BITS-1 -: 2];
         slot     = phase[PHASE_BITS-3 -: TABLE_BITS];
         coef     = quadrant[0] ? sine_q15[ENTRIES - int'(slot)] : sine_q15[slot];
         magnitude = (int'(amp_reg) * coef + 16383) / 32767;
         if (quadrant[1]) begin
            magnitude = -magnitude;
         end
         item.sample = magnitude[SAMPLE_W-1:0];
         item.last   = ({1'b0, tone_index} + 33'd1 == {1'b0, count_reg});
         expected_samples = {expected_samples, item};
         tone_phase = tone_phase + to_phase(step_reg);
         tone_index = tone_index + 32'd1;
      end
   endfunction

   initial begin
      for (int j = 0; j <= ENTRIES; j++) begin
         sine_q15[j] = quarter_wave_entry(j);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         tone_phase = '0;
         tone_index = '0;
         step_reg   = RESET_PHASE_STEP;
         offset_reg = RESET_PHASE_OFFSET;
         amp_reg    = RESET_AMPLITUDE;
         count_reg  = RESET_SAMPLE_COUNT;
         expected_samples.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample, expected none, actual %0d last %0b",
                        $time, rsp_sample, rsp_last);
               mismatch_count++;
            end else begin
               head = expected_samples.pop_front();
               if (rsp_sample !== head.sample) begin
                  $display("%0t: sample mismatch, expected %0d, actual %0d",
                           $time, head.sample, rsp_sample);
                  mismatch_count++;
               end
               if (rsp_last !== head.last) begin
                  $display("%0t: last mismatch, expected %0b, actual %0b",
                           $time, head.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               REG_PHASE_STEP:   step_reg   = csr_data;
               REG_PHASE_OFFSET: offset_reg = csr_data;
               REG_AMPLITUDE:    amp_reg    = csr_data[AMP_W-1:0];
               REG_SAMPLE_COUNT: count_reg  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_tick(req_restart);
         end
      end
      pending <= expected_samples.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// testbench top of the sine tone generator: clock, reset, stimulus, stalls and the verdict
module tb_top;
   import stg_pkg::*;

   localparam int TARGET_ITEMS = 900;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 10;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_restart;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_last;
   logic                       csr_write_enable;
   csr_index_type              csr_index;
   logic [CSR_W-1:0]           csr_data;
   int                         pending;
   int                         fail_count;
   int                         cycle_count = 0;

   // tone length as last written, to size each random tone
   logic [31:0] tone_length = RESET_SAMPLE_COUNT;
   int          sent_items  = 0;
   logic        no_gaps     = 1'b0;

   sine_tone_generator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   tone_checker tone_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .pending          (pending),
      .fail_count       (fail_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then long
   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 24);
   endfunction

   // one request transfer; returns at the edge where it is taken
   task automatic send_tick(input logic restart);
      int unsigned gap;
      gap = no_gaps ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   // register write; the caller drops the enable after the last one of a group
   task automatic write_reg(input csr_index_type index, input logic [CSR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= value;
      if (index == REG_SAMPLE_COUNT) begin
         tone_length = value;
      end
      @(posedge clock);
   endtask

   // stop sending, wait for every sample out, then let the pipeline run dry
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver back-pressure: open runs broken by stalls, sometimes long open stretches
   initial begin
      int unsigned open_run;
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         open_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 6);
         repeat (open_run) @(posedge clock);
         hold = idle_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int unsigned      roll;
      int unsigned      ticks;
      logic             first_restart;
      logic [CSR_W-1:0] value;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_restart      = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = REG_PHASE_STEP;
      csr_data         = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset, then a restart
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      settle();

      // quarter-turn steps at full scale land on each quadrant edge
      write_reg(REG_PHASE_STEP, 32'h4000_0000);
      write_reg(REG_AMPLITUDE, 32'd32767);
      write_reg(REG_SAMPLE_COUNT, 32'hFFFF_FFFF);
      csr_write_enable <= 1'b0;
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
      settle();

      // all-ones step and offset, short tone, then ticks after it has ended
      write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
      write_reg(REG_PHASE_OFFSET, 32'hFFFF_FFFF);
      write_reg(REG_SAMPLE_COUNT, 32'd3);
      csr_write_enable <= 1'b0;
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      settle();

      // zero amplitude and an empty tone
      write_reg(REG_AMPLITUDE, 32'd0);
      write_reg(REG_SAMPLE_COUNT, 32'd0);
      csr_write_enable <= 1'b0;
      send_tick(1'b1);
      send_tick(1'b0);
      settle();

      // count lowered below the position mid-tone ends the tone without a last flag
      write_reg(REG_PHASE_STEP, 32'h0123_4567);
      write_reg(REG_PHASE_OFFSET, 32'h3FFF_FFFF);
      write_reg(REG_AMPLITUDE, 32'd12345);
      write_reg(REG_SAMPLE_COUNT, 32'd5);
      csr_write_enable <= 1'b0;
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      settle();
      write_reg(REG_SAMPLE_COUNT, 32'd2);
      csr_write_enable <= 1'b0;
      repeat (2) send_tick(1'b0);
      settle();
      write_reg(REG_SAMPLE_COUNT, 32'd3);
      csr_write_enable <= 1'b0;
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      settle();

      // random tones: mostly restart-and-play-to-end, some carry on or restart midway
      while (sent_items < TARGET_ITEMS) begin
         if ($urandom_range(0, 1)) begin
            roll = $urandom_range(0, 9);
            value = (roll == 0) ? 32'd0 : (roll == 1) ? 32'hFFFF_FFFF
                  : (roll == 2) ? {16'($urandom_range(0, 65535)), 16'h0000} : $urandom;
            write_reg(REG_PHASE_STEP, value);
         end
         if ($urandom_range(0, 1)) begin
            roll = $urandom_range(0, 9);
            value = (roll == 0) ? 32'd0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
            write_reg(REG_PHASE_OFFSET, value);
         end
         if ($urandom_range(0, 1)) begin
            roll = $urandom_range(0, 9);
            value = (roll == 0) ? 32'd0 : (roll == 1) ? 32'd32767 : $urandom_range(0, 32767);
            write_reg(REG_AMPLITUDE, value);
         end
         if ($urandom_range(0, 1)) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               value = 32'd0;
            end else if (roll < 8) begin
               value = $urandom | 32'h8000_0000;
            end else if (roll < 18) begin
               value = $urandom_range(41, 200);
            end else begin
               value = $urandom_range(1, 40);
            end
            write_reg(REG_SAMPLE_COUNT, value);
         end
         csr_write_enable <= 1'b0;

         // play the tone out plus a short tail; huge tones are cut short
         if (tone_length == 0) begin
            ticks = 2;
         end else if (tone_length <= 200) begin
            ticks = tone_length + $urandom_range(0, 3);
         end else begin
            ticks = $urandom_range(10, 60);
         end
         first_restart = ($urandom_range(0, 99) < 85);
         no_gaps       = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < ticks; k++) begin
            send_tick((k == 0) ? first_restart : ($urandom_range(0, 99) < 2));
         end
         no_gaps = 1'b0;
         settle();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
